### design/mono_pixel_span_scaler_assert.svh
// assertion macros used by the span scaler controller
`ifndef MONO_PIXEL_SPAN_SCALER_ASSERT_SVH
`define MONO_PIXEL_SPAN_SCALER_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property checked on every rising clock edge out of reset
`define MPSS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define MPSS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define MPSS_ASSERT(lbl, clk, rstn, prop, msg)
`define MPSS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

### design/mpss_pkg.sv
`default_nettype none

package mpss_pkg;

    localparam int MAX_ROW_REPEAT = 8;

    localparam int COL_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 11;
    localparam int RENDER_W = 13;
    localparam int OUT_W    = 12;
    localparam int LEVEL_W  = 8;

    localparam int IDX_W    = SIZE_W;
    localparam int QUO_W    = RENDER_W;
    localparam int PROD_W   = IDX_W + RENDER_W;
    localparam int CNT_W    = $clog2(MAX_ROW_REPEAT + 1);
    localparam int CAP_W    = SIZE_W + $clog2(MAX_ROW_REPEAT + 1);
    localparam int STEP_W   = $clog2(QUO_W);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = RENDER_W;

    localparam logic [RENDER_W-1:0] RENDER_LIMIT = RENDER_W'(4096);

    localparam logic [LEVEL_W-1:0] LIT_FULL = 8'd255;
    localparam logic [LEVEL_W-1:0] LIT_DIM  = 8'd205;
    localparam logic [LEVEL_W-1:0] LIT_DARK = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RENDER_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RENDER_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCANLINE_ENABLE = 3'd4;

    localparam logic [SIZE_W-1:0]   RESET_SOURCE_WIDTH  = 11'd320;
    localparam logic [SIZE_W-1:0]   RESET_SOURCE_HEIGHT = 11'd256;
    localparam logic [RENDER_W-1:0] RESET_RENDER_WIDTH  = 13'd320;
    localparam logic [RENDER_W-1:0] RESET_RENDER_HEIGHT = 13'd256;

    // the four divisions done per item, in order
    typedef enum logic [1:0] {
        OP_COL_FIRST = 2'd0,
        OP_COL_END   = 2'd1,
        OP_ROW_FIRST = 2'd2,
        OP_ROW_END   = 2'd3
    } op_t;

    typedef struct packed {
        logic [COL_W-1:0]  src_col;
        logic [COL_W-1:0]  src_row;
        logic [BYTE_W-1:0] src_byte;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]   dest_row;
        logic [OUT_W-1:0]   col_first;
        logic [OUT_W-1:0]   col_last;
        logic [LEVEL_W-1:0] intensity;
        logic               last_span;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic div_last;
        logic emit;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic out_free;
        logic span_last;
    } status_t;

endpackage

`default_nettype wire

### design/mpss_datapath.sv
`default_nettype none

module mpss_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [mpss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mpss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire mpss_pkg::in_item_t               s_item,
    output mpss_pkg::out_item_t                   m_item,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    input  wire mpss_pkg::cmd_t                   cmd,
    output mpss_pkg::status_t                     status
);
    import mpss_pkg::*;

    logic [SIZE_W-1:0]   source_width_reg;
    logic [SIZE_W-1:0]   source_height_reg;
    logic [RENDER_W-1:0] render_width_reg;
    logic [RENDER_W-1:0] render_height_reg;
    logic                scanline_reg;
    logic                m_valid_reg;

    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    row_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [RENDER_W-1:0] rw_eff_reg;
    logic [RENDER_W-1:0] rh_eff_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [QUO_W-1:0]    low_reg;
    logic [OUT_W-1:0]    c0_reg;
    logic [OUT_W-1:0]    c1_reg;
    logic [OUT_W-1:0]    r0_reg;
    logic [OUT_W-1:0]    r1_reg;
    logic [OUT_W-1:0]    dy_reg;
    logic [CNT_W-1:0]    n_reg;
    out_item_t           m_item_reg;

    logic [RENDER_W-1:0] rw_clamp;
    logic [RENDER_W-1:0] rh_clamp;
    logic [CAP_W-1:0]    rh_cap;
    logic [RENDER_W-1:0] rh_eff;
    logic [IDX_W-1:0]    idx_sel;
    logic [RENDER_W-1:0] dst_sel;
    logic [SIZE_W-1:0]   divisor;
    logic [PROD_W-1:0]   product;
    logic [SIZE_W:0]     trial;
    logic                q_bit;
    logic [SIZE_W-1:0]   rem_next;
    logic [QUO_W-1:0]    quotient;
    logic [OUT_W-1:0]    span_end;
    logic                lit;
    logic [LEVEL_W-1:0]  level;
    logic                span_last;

    // effective render sizes
    always_comb begin
        rw_clamp = render_width_reg;
        if (render_width_reg == '0) begin
            rw_clamp = RENDER_W'(1);
        end else if (render_width_reg > RENDER_LIMIT) begin
            rw_clamp = RENDER_LIMIT;
        end
        rh_clamp = render_height_reg;
        if (render_height_reg == '0) begin
            rh_clamp = RENDER_W'(1);
        end else if (render_height_reg > RENDER_LIMIT) begin
            rh_clamp = RENDER_LIMIT;
        end
        rh_cap = CAP_W'(source_height_reg) * CAP_W'(MAX_ROW_REPEAT);
        rh_eff = (CAP_W'(rh_clamp) > rh_cap) ? rh_cap[RENDER_W-1:0] : rh_clamp;
    end

    // operand selection for the shared multiply and divide
    always_comb begin
        unique case (cmd.op)
            OP_COL_FIRST: begin
                idx_sel = IDX_W'(col_reg);
                dst_sel = rw_eff_reg;
                divisor = source_width_reg;
            end
            OP_COL_END: begin
                idx_sel = IDX_W'(col_reg) + IDX_W'(1);
                dst_sel = rw_eff_reg;
                divisor = source_width_reg;
            end
            OP_ROW_FIRST: begin
                idx_sel = IDX_W'(row_reg);
                dst_sel = rh_eff_reg;
                divisor = source_height_reg;
            end
            OP_ROW_END: begin
                idx_sel = IDX_W'(row_reg) + IDX_W'(1);
                dst_sel = rh_eff_reg;
                divisor = source_height_reg;
            end
            default: begin
                idx_sel = '0;
                dst_sel = '0;
                divisor = '0;
            end
        endcase
        product = PROD_W'(idx_sel) * PROD_W'(dst_sel);
    end

    // one restoring division step
    always_comb begin
        trial    = {rem_reg, low_reg[QUO_W-1]};
        q_bit    = trial >= {1'b0, divisor};
        rem_next = q_bit ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
        quotient = {low_reg[QUO_W-2:0], q_bit};
    end

    // end of a span: one before the next start, never below the start
    always_comb begin
        if (quotient > QUO_W'(c0_reg) && cmd.op == OP_COL_END) begin
            span_end = OUT_W'(quotient - QUO_W'(1));
        end else if (quotient > QUO_W'(r0_reg) && cmd.op == OP_ROW_END) begin
            span_end = OUT_W'(quotient - QUO_W'(1));
        end else if (cmd.op == OP_COL_END) begin
            span_end = c0_reg;
        end else begin
            span_end = r0_reg;
        end
    end

    always_comb begin
        lit = byte_reg[3'd7 - col_reg[2:0]];
        if (!lit) begin
            level = LIT_DARK;
        end else if (scanline_reg && !dy_reg[1]) begin
            level = LIT_DIM;
        end else begin
            level = LIT_FULL;
        end
        span_last = (dy_reg == r1_reg) || (n_reg == CNT_W'(MAX_ROW_REPEAT - 1));
    end

    // configuration and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= RESET_SOURCE_WIDTH;
            source_height_reg <= RESET_SOURCE_HEIGHT;
            render_width_reg  <= RESET_RENDER_WIDTH;
            render_height_reg <= RESET_RENDER_HEIGHT;
            scanline_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SOURCE_WIDTH:    source_width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_SOURCE_HEIGHT:   source_height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_RENDER_WIDTH:    render_width_reg  <= cfg_data;
                    CFG_RENDER_HEIGHT:   render_height_reg <= cfg_data;
                    CFG_SCANLINE_ENABLE: scanline_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg    <= s_item.src_col;
            row_reg    <= s_item.src_row;
            byte_reg   <= s_item.src_byte;
            rw_eff_reg <= rw_clamp;
            rh_eff_reg <= rh_eff;
        end
        if (cmd.mul) begin
            rem_reg <= product[PROD_W-1:QUO_W];
            low_reg <= product[QUO_W-1:0];
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            low_reg <= quotient;
        end
        if (cmd.div_step && cmd.div_last) begin
            unique case (cmd.op)
                OP_COL_FIRST: c0_reg <= quotient[OUT_W-1:0];
                OP_COL_END:   c1_reg <= span_end;
                OP_ROW_FIRST: r0_reg <= quotient[OUT_W-1:0];
                OP_ROW_END: begin
                    r1_reg <= span_end;
                    dy_reg <= r0_reg;
                    n_reg  <= '0;
                end
                default: ;
            endcase
        end
        if (cmd.emit) begin
            m_item_reg.dest_row  <= dy_reg;
            m_item_reg.col_first <= c0_reg;
            m_item_reg.col_last  <= c1_reg;
            m_item_reg.intensity <= level;
            m_item_reg.last_span <= span_last;
            dy_reg               <= dy_reg + OUT_W'(1);
            n_reg                <= n_reg + CNT_W'(1);
        end
    end

    assign m_item  = m_item_reg;
    assign m_valid = m_valid_reg;

    assign status.in_range  = (SIZE_W'(col_reg) < source_width_reg) &&
                              (SIZE_W'(row_reg) < source_height_reg);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.span_last = span_last;

endmodule

`default_nettype wire

### design/mpss_ctrl.sv
`default_nettype none

`include "mono_pixel_span_scaler_assert.svh"

module mpss_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mpss_pkg::status_t status,
    output mpss_pkg::cmd_t         cmd
);
    import mpss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                op_next    = OP_COL_FIRST;
                state_next = status.in_range ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_last = (step_reg == DIV_LAST);
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST) begin
                    unique case (op_reg)
                        OP_COL_FIRST: begin
                            op_next    = OP_COL_END;
                            state_next = S_MUL;
                        end
                        OP_COL_END: begin
                            op_next    = OP_ROW_FIRST;
                            state_next = S_MUL;
                        end
                        OP_ROW_FIRST: begin
                            op_next    = OP_ROW_END;
                            state_next = S_MUL;
                        end
                        OP_ROW_END: state_next = S_EMIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.span_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_COL_FIRST;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    `MPSS_ASSERT(a_emit_needs_room, aclk, aresetn, !cmd.emit || status.out_free, "no room")
    `MPSS_ASSERT(a_steps, aclk, aresetn, state_reg != S_DIV || step_reg <= DIV_LAST, "overrun")
    `MPSS_ASSERT_NEXT(a_op_advance, aclk, aresetn,
        state_reg == S_DIV && step_reg == DIV_LAST && op_reg != OP_ROW_END,
        state_reg == S_MUL, "division sequence did not move to next operand")
    `MPSS_ASSERT_NEXT(a_out_of_range, aclk, aresetn,
        state_reg == S_CHECK && !status.in_range,
        state_reg == S_IDLE, "pixel outside source was not dropped")

endmodule

`default_nettype wire

### design/mono_pixel_span_scaler.sv
`default_nettype none

// nearest-neighbor scaler for one pixel of a 1-bit-per-pixel image. each item
// carries a source column, row and the framebuffer byte holding the pixel
// (leftmost pixel in bit 7). the pixel is drawn as one horizontal span on every
// destination row its source row covers, one result item per row in ascending
// order, last_span marking the final one; pixels outside the source size give
// no result. an item is accepted, range-checked, then goes through four
// multiply/divide passes (one multiply plus 13 restoring-division steps each on
// the shared divider), then its spans go out one per cycle while the output
// register is free, up to MAX_ROW_REPEAT spans per item. the next item is
// accepted as soon as the last span sits in the output register.
// configuration registers are written through the cfg port (always ready) and
// must only change while the block is idle.

module mono_pixel_span_scaler (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mpss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mpss_pkg::CFG_DATA_W-1:0]  cfg_data,
    // source pixel items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire mpss_pkg::in_item_t               s_item,
    // span items
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output mpss_pkg::out_item_t                   m_item
);
    import mpss_pkg::*;

    cmd_t    cmd;
    status_t status;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: accept, range check, divide passes, span emission
    mpss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // config registers, shared multiplier and divider, span registers, output stage
    mpss_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_item    (m_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mpss_pkg::*;

    // longest quiet stretch allowed with no item moving on any channel
    localparam int STALL_LIMIT   = 4000;
    // cycles waited after the last span to let the block go idle
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_PIXELS  = 12;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;

    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    mono_pixel_span_scaler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // shadow copy of the scaler registers, updated as each write is accepted
    logic [SIZE_W-1:0]   src_width   = RESET_SOURCE_WIDTH;
    logic [SIZE_W-1:0]   src_height  = RESET_SOURCE_HEIGHT;
    logic [RENDER_W-1:0] rnd_width   = RESET_RENDER_WIDTH;
    logic [RENDER_W-1:0] rnd_height  = RESET_RENDER_HEIGHT;
    logic                scan_on     = 1'b0;

    in_item_t  pixel_fifo[$];     // pixels waiting to be offered
    out_item_t pending_spans[$];  // spans predicted but not yet seen

    int idle_max     = 6;         // upper bound of the per-item wait, both sides
    int unsigned pixel_gap = 0;
    int unsigned span_wait = 0;
    int stall_cycles = 0;
    int mismatches   = 0;
    int pixels_taken = 0;
    int spans_seen   = 0;
    int reg_writes   = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // render size as the scaler uses it: zero acts as one, big values saturate
    function automatic int unsigned render_clamp(int unsigned v);
        if (v < 1) return 1;
        if (v > RENDER_LIMIT) return RENDER_LIMIT;
        return v;
    endfunction

    // destination range hit by source index idx, end raised to start and kept on screen
    function automatic void cover_range(input int unsigned idx, input int unsigned src,
                                        input int unsigned dst,
                                        output int unsigned first, output int unsigned last);
        int unsigned lo;
        int unsigned hi;
        lo = (idx * dst) / src;
        hi = ((idx + 1) * dst) / src;
        last = (hi == 0) ? 0 : hi - 1;
        if (hi == 0 || last < lo) last = lo;
        if (last >= dst) last = dst - 1;
        first = lo;
    endfunction

    // expected spans for one accepted pixel under the current register values
    function automatic void predict_spans(in_item_t px);
        int unsigned col;
        int unsigned row;
        int unsigned rw;
        int unsigned rh;
        int unsigned cap;
        int unsigned c0;
        int unsigned c1;
        int unsigned r0;
        int unsigned r1;
        int unsigned dy;
        int          n;
        logic        lit;
        out_item_t   sp;
        col = px.src_col;
        row = px.src_row;
        // pixel outside the source image (covers a zero source size too)
        if (col >= src_width || row >= src_height) return;
        rw  = render_clamp(rnd_width);
        rh  = render_clamp(rnd_height);
        // no more than MAX_ROW_REPEAT destination rows per source row
        cap = MAX_ROW_REPEAT * src_height;
        if (rh > cap) rh = cap;
        cover_range(col, src_width, rw, c0, c1);
        cover_range(row, src_height, rh, r0, r1);
        // leftmost pixel of the byte sits in bit 7
        lit = px.src_byte[3'd7 - px.src_col[2:0]];
        n = 0;
        for (dy = r0; dy <= r1 && n < MAX_ROW_REPEAT; dy++) begin
            sp.dest_row  = OUT_W'(dy);
            sp.col_first = OUT_W'(c0);
            sp.col_last  = OUT_W'(c1);
            if (!lit)
                sp.intensity = LIT_DARK;
            else if (scan_on && dy[1:0] < 2'd2)
                sp.intensity = LIT_DIM;
            else
                sp.intensity = LIT_FULL;
            sp.last_span = (dy == r1) || (n == MAX_ROW_REPEAT - 1);
            pending_spans.push_back(sp);
            n++;
        end
    endfunction

    function automatic void report_span(string what, out_item_t want, out_item_t got);
        if (mismatches < 10) begin
            $display("span mismatch (%s) at %0t: expected row %0d cols %0d..%0d level %0d last %0b",
                     what, $realtime, want.dest_row, want.col_first, want.col_last,
                     want.intensity, want.last_span);
            $display("    got row %0d cols %0d..%0d level %0d last %0b",
                     got.dest_row, got.col_first, got.col_last, got.intensity,
                     got.last_span);
        end
        mismatches++;
    endfunction

    // compare one span from the block with the oldest prediction
    function automatic void check_span(out_item_t got);
        out_item_t want;
        string     diff;
        spans_seen++;
        if (pending_spans.size() == 0) begin
            report_span("nothing expected", '0, got);
            return;
        end
        want = pending_spans.pop_front();
        diff = "";
        if (got.dest_row  !== want.dest_row)  diff = {diff, " dest_row"};
        if (got.col_first !== want.col_first) diff = {diff, " col_first"};
        if (got.col_last  !== want.col_last)  diff = {diff, " col_last"};
        if (got.intensity !== want.intensity) diff = {diff, " intensity"};
        if (got.last_span !== want.last_span) diff = {diff, " last_span"};
        if (diff != "") report_span(diff, want, got);
    endfunction

    // pixel driver: offers queued pixels with a random wait before each one,
    // predicts the spans at the edge where the pixel is taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_spans(s_item);
                void'(pixel_fifo.pop_front());
                pixels_taken++;
                pixel_gap = $urandom_range(0, idle_max);
            end
            if (s_valid && !s_ready) begin
                // hold the offered pixel unchanged
            end else if (pixel_fifo.size() != 0 && pixel_gap == 0) begin
                s_item  <= pixel_fifo[0];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                if (pixel_gap > 0) pixel_gap--;
            end
        end
    end

    // span receiver: checks each span, then stalls a random number of cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_span(m_item);
                span_wait = $urandom_range(0, idle_max);
            end else if (span_wait > 0) begin
                span_wait--;
            end
            m_ready <= (span_wait == 0);
        end
    end

    // watchdog on cycles where no item moves anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d spans outstanding",
                     stall_cycles, pending_spans.size());
            $display("tb: failure");
            $finish;
        end
    end

    // one register write through the cfg channel; shadow updated on acceptance
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SOURCE_WIDTH:    src_width  = data[SIZE_W-1:0];
            CFG_SOURCE_HEIGHT:   src_height = data[SIZE_W-1:0];
            CFG_RENDER_WIDTH:    rnd_width  = data[RENDER_W-1:0];
            CFG_RENDER_HEIGHT:   rnd_height = data[RENDER_W-1:0];
            CFG_SCANLINE_ENABLE: scan_on    = data[0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input int sw, input int sh, input int rw, input int rh,
                             input int sc);
        write_reg(CFG_SOURCE_WIDTH,    CFG_DATA_W'(sw));
        write_reg(CFG_SOURCE_HEIGHT,   CFG_DATA_W'(sh));
        write_reg(CFG_RENDER_WIDTH,    CFG_DATA_W'(rw));
        write_reg(CFG_RENDER_HEIGHT,   CFG_DATA_W'(rh));
        write_reg(CFG_SCANLINE_ENABLE, CFG_DATA_W'(sc));
    endtask

    // shared send: hands one pixel to the driver
    task automatic queue_pixel(input int unsigned col, input int unsigned row,
                               input int unsigned pix_byte);
        in_item_t px;
        px.src_col  = COL_W'(col);
        px.src_row  = COL_W'(row);
        px.src_byte = BYTE_W'(pix_byte);
        pixel_fifo.push_back(px);
    endtask

    // wait for every pixel taken and every span seen, then let the block go idle
    task automatic settle_idle();
        while (pixel_fifo.size() != 0 || pending_spans.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // reset register values: bit select extremes and pixels just off the image
    task automatic test_reset_config();
        queue_pixel(0, 0, 8'h80);
        queue_pixel(319, 255, 8'h01);
        queue_pixel(7, 3, 8'hFE);
        queue_pixel(320, 0, 8'hFF);
        queue_pixel(0, 256, 8'hFF);
        queue_pixel(1023, 1023, 8'hFF);
        settle_idle();
    endtask

    // scanline dimming on full 8-row repeats, lit and dark
    task automatic test_scanline_rows();
        write_reg(CFG_SCANLINE_ENABLE, 1);
        write_reg(CFG_RENDER_HEIGHT, 2048);
        queue_pixel(5, 10, 8'hFF);
        queue_pixel(6, 255, 8'h00);
        settle_idle();
    endtask

    // render size of zero acts as one; oversize render saturates, then row cap
    task automatic test_render_clamps();
        write_reg(CFG_RENDER_WIDTH, 0);
        write_reg(CFG_RENDER_HEIGHT, 0);
        queue_pixel(100, 100, 8'hFF);
        queue_pixel(319, 255, 8'h55);
        settle_idle();
        write_reg(CFG_RENDER_WIDTH, 13'h1FFF);
        write_reg(CFG_RENDER_HEIGHT, 13'h1FFF);
        queue_pixel(319, 255, 8'hFF);
        queue_pixel(0, 0, 8'hAA);
        settle_idle();
    endtask

    // zero and masked source sizes, tiny source heights, ignored register indexes
    task automatic test_source_sizes();
        write_reg(CFG_SOURCE_WIDTH, 0);
        queue_pixel(0, 0, 8'hFF);
        settle_idle();
        // data wider than the register is masked to 11 bits
        write_reg(CFG_SOURCE_WIDTH, 13'h1FFF);
        write_reg(CFG_SOURCE_HEIGHT, 1);
        write_reg(CFG_RENDER_HEIGHT, 4096);
        queue_pixel(1023, 0, 8'h01);
        queue_pixel(512, 0, 8'h7F);
        settle_idle();
        write_reg(CFG_SOURCE_HEIGHT, 3);
        queue_pixel(0, 2, 8'h80);
        settle_idle();
        write_reg(CFG_SOURCE_HEIGHT, 13'h1FFF);
        queue_pixel(0, 1023, 8'h80);
        settle_idle();
        write_reg(CFG_SOURCE_HEIGHT, 0);
        queue_pixel(1, 0, 8'hFF);
        settle_idle();
        // writes past the last register must change nothing
        for (int i = CFG_SCANLINE_ENABLE + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), '0);
        queue_pixel(9, 0, 8'h40);
        settle_idle();
    endtask

    // random phases: one register set per phase, extremes first, mostly in-range
    // pixels with some off-image noise; idle on both sides every other phase
    task automatic test_random_phases();
        int unsigned sw;
        int unsigned sh;
        int unsigned rw;
        int unsigned rh;
        int unsigned col_lim;
        int unsigned row_lim;
        int unsigned col;
        int unsigned row;
        int          kept;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                write_all(1, 1, 1, 1, 0);
            end else if (phase == 1) begin
                write_all(1024, 1024, 4096, 4096, 1);
            end else begin
                sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 1024);
                sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 64);
                rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 4096);
                // mostly 0..10 rows per source row so every span count shows up
                rh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 10 * sh);
                write_all(sw, sh, rw, rh, $urandom_range(0, 1));
            end
            idle_max = (phase % 2 == 0) ? 6 : 0;
            col_lim = (src_width > 1024) ? 1024 : src_width;
            row_lim = (src_height > 1024) ? 1024 : src_height;
            kept = 0;
            for (int tries = 0; kept < PHASE_PIXELS && tries < 3 * PHASE_PIXELS; tries++) begin
                if (col_lim == 0 || row_lim == 0 || $urandom_range(0, 4) == 0) begin
                    col = $urandom_range(0, 1023);
                    row = $urandom_range(0, 1023);
                end else begin
                    col = $urandom_range(0, col_lim - 1);
                    row = $urandom_range(0, row_lim - 1);
                end
                if (col < src_width && row < src_height) kept++;
                queue_pixel(col, row, $urandom_range(0, 255));
            end
            settle_idle();
        end
        idle_max = 6;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_scanline_rows();
        test_render_clamps();
        test_source_sizes();
        test_random_phases();
        settle_idle();
        if (pending_spans.size() != 0) begin
            $display("%0d predicted spans never arrived", pending_spans.size());
            mismatches += pending_spans.size();
        end
        $display("summary: %0d pixels taken, %0d spans checked, %0d register writes",
                 pixels_taken, spans_seen, reg_writes);
        $display("summary: %0d mismatches over reset, clamp, scanline and random size phases",
                 mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
